// ===== design/bcfd_pkg.sv =====
// Shared constants, the open-circuit-voltage table, codes and handoff types
// for the BMS CAN frame decoder. No dependencies.
package bcfd_pkg;

    localparam int SOC_TABLE_POINTS = 21;
    localparam int SOC_FULL_SCALE   = 10000;

    localparam int CELL_W   = 16;
    localparam int DSUM_W   = CELL_W + 1;
    localparam int SOC_W    = 14;
    localparam int SERIES_W = 7;
    localparam int PACK_W   = 22;
    localparam int KIND_W   = 3;

    localparam int PT_IDX_W  = $clog2(SOC_TABLE_POINTS);
    localparam int SEG_IDX_W = (SOC_TABLE_POINTS > 2) ? $clog2(SOC_TABLE_POINTS - 1) : 1;
    // Interpolation term and denominator stay below SOC_TABLE_POINTS * 2^DSUM_W.
    localparam int TERM_W = DSUM_W + $clog2(SOC_TABLE_POINTS) + 1;
    localparam int NUM_W  = TERM_W + SOC_W;

    localparam logic [SERIES_W-1:0] SERIES_RESET     = SERIES_W'(29);
    localparam logic [CELL_W-1:0]   CURRENT_MIDSCALE = 16'h8000;
    localparam logic [PACK_W-1:0]   PACK_VOLTS_MAX   = '1;

    localparam logic [10:0] ID_FAULT = 11'h001;
    localparam logic [10:0] ID_TEMPS = 11'h108;
    localparam logic [10:0] ID_CELLS = 11'h109;
    localparam logic [10:0] ID_SPEED = 11'h208;

    localparam logic [KIND_W-1:0] KIND_IGNORED = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FAULT   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_TEMPS   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_CELLS   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_SPEED   = 3'd4;

    // Cell voltage in 0.1 mV at 0, 5, 10, ... 100 percent charge.
    localparam logic [CELL_W-1:0] OCV_TABLE [SOC_TABLE_POINTS] = '{
        16'd25000, 16'd28710, 16'd30430, 16'd31600, 16'd32690,
        16'd33710, 16'd34290, 16'd34760, 16'd35210, 16'd35720,
        16'd36290, 16'd36800, 16'd37260, 16'd37650, 16'd38040,
        16'd38650, 16'd39230, 16'd39550, 16'd39750, 16'd39980, 16'd41110
    };

    // Table point scaled to the doubled-mean domain.
    function automatic logic [DSUM_W-1:0] ocv_doubled(input logic [PT_IDX_W-1:0] idx);
        return {OCV_TABLE[idx], 1'b0};
    endfunction

    typedef struct packed {
        logic              start;
        logic [DSUM_W-1:0] dsum;
    } soc_req_t;

    typedef struct packed {
        logic             done;
        logic [SOC_W-1:0] soc;
    } soc_rsp_t;

endpackage

// ===== design/bms_can_frame_decoder.sv =====
// Every frame passes the decode state, then waits in the emit state for a free output
// register; a cell frame first waits in the SoC state for the interpolator, which skips
// its one-segment-per-cycle table walk and serial divider for a mean at or beyond the
// table ends. One frame is in work at a time; the next request is taken in the cycle
// after its result reaches the output register, even while it is not yet taken.
// Reset (rst_n, asynchronous, active low) clears all held values and sets series_cells to 29.
module bms_can_frame_decoder
    import bcfd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // Configuration: series_cells.
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [SERIES_W-1:0] cfg_data,
    // Frame input.
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // From bit 0: frame_id[11:0], frame_length[15:12], byte_0 .. byte_7 [79:16].
    input  logic [79:0]         s_axis_tdata,
    // Snapshot output.
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // From bit 0: fault_active, charge_state[14:1], temp_low[30:15], temp_high[46:31],
    // cell_high[62:47], cell_low[78:63], current_mag[94:79], pack_volts[116:95],
    // speed_bits[148:117], zero fill [151:149].
    output logic [151:0]        m_axis_tdata,
    // frame_kind[2:0].
    output logic [KIND_W-1:0]   m_axis_tuser
);

    // The frame as it sits in tdata, first field in the lowest bits.
    typedef struct packed {
        logic [7:0]  byte_7;
        logic [7:0]  byte_6;
        logic [7:0]  byte_5;
        logic [7:0]  byte_4;
        logic [7:0]  byte_3;
        logic [7:0]  byte_2;
        logic [7:0]  byte_1;
        logic [7:0]  byte_0;
        logic [3:0]  frame_length;
        logic [11:0] frame_id;
    } frame_t;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_DECODE = 2'd1;
    localparam logic [1:0] ST_SOC    = 2'd2;
    localparam logic [1:0] ST_EMIT   = 2'd3;

    localparam int PAD_W = 152 - 149;

    logic [1:0]          state_reg, state_next;
    frame_t              frame_reg, frame_next;
    logic [KIND_W-1:0]   kind_reg, kind_next;
    logic [DSUM_W-1:0]   dsum_reg, dsum_next;
    logic [SERIES_W-1:0] series_reg, series_next;

    // Values held between frames.
    logic                fault_reg, fault_next;
    logic [SOC_W-1:0]    soc_reg, soc_next;
    logic [15:0]         temp_low_reg, temp_low_next;
    logic [15:0]         temp_high_reg, temp_high_next;
    logic [CELL_W-1:0]   cell_high_reg, cell_high_next;
    logic [CELL_W-1:0]   cell_low_reg, cell_low_next;
    logic [15:0]         current_reg, current_next;
    logic [PACK_W-1:0]   pack_volts_reg, pack_volts_next;
    logic [31:0]         speed_reg, speed_next;

    // Output register.
    logic                m_valid_reg, m_valid_next;
    logic [151:0]        m_data_reg, m_data_next;
    logic [KIND_W-1:0]   m_user_reg, m_user_next;

    logic [10:0]         frame_id11;
    logic [CELL_W-1:0]   current_code;
    logic [CELL_W-1:0]   new_cell_high;
    logic [CELL_W-1:0]   new_cell_low;
    logic [DSUM_W+SERIES_W-1:0] pack_prod;
    logic [DSUM_W+SERIES_W-2:0] pack_half;
    logic                out_load;
    soc_req_t            soc_req;
    soc_rsp_t            soc_rsp;

    assign frame_id11    = frame_reg.frame_id[10:0];
    assign current_code  = {frame_reg.byte_4, frame_reg.byte_5};
    assign new_cell_high = {frame_reg.byte_0, frame_reg.byte_1};
    assign new_cell_low  = {frame_reg.byte_2, frame_reg.byte_3};

    // Pack voltage is series_cells times the doubled mean, halved and saturated.
    assign pack_prod = (DSUM_W+SERIES_W)'(dsum_reg) * (DSUM_W+SERIES_W)'(series_reg);
    assign pack_half = pack_prod[DSUM_W+SERIES_W-1:1];

    assign out_load = (state_reg == ST_EMIT) && (!m_valid_reg || m_axis_tready);

    assign soc_req.start = (state_reg == ST_DECODE) && (kind_next == KIND_CELLS);
    assign soc_req.dsum  = DSUM_W'(new_cell_high) + DSUM_W'(new_cell_low);

    always_comb
    begin
        state_next      = state_reg;
        frame_next      = frame_reg;
        kind_next       = kind_reg;
        dsum_next       = dsum_reg;
        series_next     = series_reg;
        fault_next      = fault_reg;
        soc_next        = soc_reg;
        temp_low_next   = temp_low_reg;
        temp_high_next  = temp_high_reg;
        cell_high_next  = cell_high_reg;
        cell_low_next   = cell_low_reg;
        current_next    = current_reg;
        pack_volts_next = pack_volts_reg;
        speed_next      = speed_reg;
        m_valid_next    = m_valid_reg && !m_axis_tready;
        m_data_next     = m_data_reg;
        m_user_next     = m_user_reg;

        if (cfg_valid)
        begin
            series_next = cfg_data;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    frame_next = frame_t'(s_axis_tdata);
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                // Frames shorter than their id needs, and unknown ids, change nothing.
                kind_next  = KIND_IGNORED;
                state_next = ST_EMIT;
                if (frame_id11 == ID_FAULT && frame_reg.frame_length >= 4'd1)
                begin
                    kind_next  = KIND_FAULT;
                    fault_next = (frame_reg.byte_0 == 8'd1);
                end
                else if (frame_id11 == ID_TEMPS && frame_reg.frame_length >= 4'd4)
                begin
                    kind_next      = KIND_TEMPS;
                    temp_low_next  = {frame_reg.byte_0, frame_reg.byte_1};
                    temp_high_next = {frame_reg.byte_2, frame_reg.byte_3};
                end
                else if (frame_id11 == ID_CELLS && frame_reg.frame_length >= 4'd6)
                begin
                    kind_next      = KIND_CELLS;
                    cell_high_next = new_cell_high;
                    cell_low_next  = new_cell_low;
                    dsum_next      = soc_req.dsum;
                    if (current_code >= CURRENT_MIDSCALE)
                    begin
                        current_next = current_code - CURRENT_MIDSCALE;
                    end
                    else
                    begin
                        current_next = CURRENT_MIDSCALE - current_code;
                    end
                    state_next = ST_SOC;
                end
                else if (frame_id11 == ID_SPEED && frame_reg.frame_length >= 4'd4)
                begin
                    kind_next  = KIND_SPEED;
                    speed_next = {frame_reg.byte_3, frame_reg.byte_2,
                                  frame_reg.byte_1, frame_reg.byte_0};
                end
            end
            ST_SOC:
            begin
                if (soc_rsp.done)
                begin
                    soc_next = soc_rsp.soc;
                    if (pack_half > (DSUM_W+SERIES_W-1)'(PACK_VOLTS_MAX))
                    begin
                        pack_volts_next = PACK_VOLTS_MAX;
                    end
                    else
                    begin
                        pack_volts_next = pack_half[PACK_W-1:0];
                    end
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_load)
                begin
                    m_valid_next = 1'b1;
                    m_user_next  = kind_reg;
                    m_data_next  = {{PAD_W{1'b0}}, speed_reg, pack_volts_reg, current_reg,
                                    cell_low_reg, cell_high_reg, temp_high_reg,
                                    temp_low_reg, soc_reg, fault_reg};
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            series_reg     <= SERIES_RESET;
            fault_reg      <= 1'b0;
            soc_reg        <= '0;
            temp_low_reg   <= '0;
            temp_high_reg  <= '0;
            cell_high_reg  <= '0;
            cell_low_reg   <= '0;
            current_reg    <= '0;
            pack_volts_reg <= '0;
            speed_reg      <= '0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            series_reg     <= series_next;
            fault_reg      <= fault_next;
            soc_reg        <= soc_next;
            temp_low_reg   <= temp_low_next;
            temp_high_reg  <= temp_high_next;
            cell_high_reg  <= cell_high_next;
            cell_low_reg   <= cell_low_next;
            current_reg    <= current_next;
            pack_volts_reg <= pack_volts_next;
            speed_reg      <= speed_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        frame_reg  <= frame_next;
        kind_reg   <= kind_next;
        dsum_reg   <= dsum_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    bcfd_soc_interp u_soc (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (soc_req),
        .rsp   (soc_rsp)
    );

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

endmodule

// ===== design/bcfd_serial_div.sv =====
// Restoring divider that produces one quotient bit per cycle.
// Depends on bcfd_pkg for the numerator, denominator and quotient widths.
module bcfd_serial_div
    import bcfd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [NUM_W-1:0]  num,
    input  logic [TERM_W-1:0] den,
    output logic              done,
    output logic [SOC_W-1:0]  quot
);

    localparam int CNT_W = $clog2(SOC_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] den_sh_reg, den_sh_next;
    logic [SOC_W-1:0] quot_reg, quot_next;

    always_comb
    begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        rem_next    = rem_reg;
        den_sh_next = den_sh_reg;
        quot_next   = quot_reg;
        if (start)
        begin
            busy_next   = 1'b1;
            cnt_next    = CNT_W'(SOC_W - 1);
            rem_next    = num;
            den_sh_next = NUM_W'(den) << (SOC_W - 1);
            quot_next   = '0;
        end
        else if (busy_reg)
        begin
            if (rem_reg >= den_sh_reg)
            begin
                rem_next  = rem_reg - den_sh_reg;
                quot_next = {quot_reg[SOC_W-2:0], 1'b1};
            end
            else
            begin
                quot_next = {quot_reg[SOC_W-2:0], 1'b0};
            end
            den_sh_next = den_sh_reg >> 1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg    <= rem_next;
        den_sh_reg <= den_sh_next;
        quot_reg   <= quot_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// ===== design/bcfd_soc_interp.sv =====
// State-of-charge interpolation: clamps, a serial walk over the table segments,
// two multiply stages and the serial divider. Depends on bcfd_pkg, bcfd_serial_div.
module bcfd_soc_interp
    import bcfd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  soc_req_t req,
    output soc_rsp_t rsp
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SEARCH = 3'd1;
    localparam logic [2:0] S_MUL1   = 3'd2;
    localparam logic [2:0] S_MUL2   = 3'd3;
    localparam logic [2:0] S_DIVGO  = 3'd4;
    localparam logic [2:0] S_DIV    = 3'd5;

    logic [2:0]           state_reg, state_next;
    logic                 done_reg, done_next;
    logic [SOC_W-1:0]     soc_reg, soc_next;
    logic [SEG_IDX_W-1:0] idx_reg, idx_next;
    logic [DSUM_W-1:0]    dsum_reg, dsum_next;
    logic [DSUM_W-1:0]    span_reg, span_next;
    logic [DSUM_W-1:0]    off_reg, off_next;
    logic [TERM_W-1:0]    term_reg, term_next;
    logic [TERM_W-1:0]    den_reg, den_next;
    logic [NUM_W-1:0]     num_reg, num_next;

    logic [DSUM_W-1:0] seg_lo;
    logic [DSUM_W-1:0] seg_hi;
    logic              div_done;
    logic [SOC_W-1:0]  div_quot;

    assign seg_lo = ocv_doubled(PT_IDX_W'(idx_reg));
    assign seg_hi = ocv_doubled(PT_IDX_W'(idx_reg) + 1'b1);

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        soc_next   = soc_reg;
        idx_next   = idx_reg;
        dsum_next  = dsum_reg;
        span_next  = span_reg;
        off_next   = off_reg;
        term_next  = term_reg;
        den_next   = den_reg;
        num_next   = num_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req.start)
                begin
                    dsum_next = req.dsum;
                    idx_next  = '0;
                    if (req.dsum <= ocv_doubled(PT_IDX_W'(0)))
                    begin
                        soc_next  = '0;
                        done_next = 1'b1;
                    end
                    else if (req.dsum >= ocv_doubled(PT_IDX_W'(SOC_TABLE_POINTS - 1)))
                    begin
                        soc_next  = SOC_W'(SOC_FULL_SCALE);
                        done_next = 1'b1;
                    end
                    else
                    begin
                        state_next = S_SEARCH;
                    end
                end
            end
            S_SEARCH:
            begin
                // The first matching segment wins, so a shared point uses the lower one.
                if (seg_lo <= dsum_reg && dsum_reg <= seg_hi)
                begin
                    span_next  = seg_hi - seg_lo;
                    off_next   = dsum_reg - seg_lo;
                    state_next = S_MUL1;
                end
                else if (idx_reg == SEG_IDX_W'(SOC_TABLE_POINTS - 2))
                begin
                    soc_next   = '0;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_MUL1:
            begin
                // A flat segment reports its lower point: idx * full / (points - 1).
                if (span_reg == '0)
                begin
                    term_next = TERM_W'(idx_reg);
                    den_next  = TERM_W'(SOC_TABLE_POINTS - 1);
                end
                else
                begin
                    term_next = TERM_W'(idx_reg) * TERM_W'(span_reg) + TERM_W'(off_reg);
                    den_next  = TERM_W'(span_reg) * TERM_W'(SOC_TABLE_POINTS - 1);
                end
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                num_next   = NUM_W'(term_reg) * NUM_W'(SOC_FULL_SCALE);
                state_next = S_DIVGO;
            end
            S_DIVGO:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    soc_next   = div_quot;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        soc_reg  <= soc_next;
        idx_reg  <= idx_next;
        dsum_reg <= dsum_next;
        span_reg <= span_next;
        off_reg  <= off_next;
        term_reg <= term_next;
        den_reg  <= den_next;
        num_reg  <= num_next;
    end

    bcfd_serial_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == S_DIVGO),
        .num   (num_reg),
        .den   (den_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign rsp.done = done_reg;
    assign rsp.soc  = soc_reg;

endmodule

// ===== design/bcfd_checker.sv =====
// Port-level checks for the BMS CAN frame decoder and the bind that attaches them.
// Depends on bcfd_pkg and bms_can_frame_decoder.
module bcfd_checker
    import bcfd_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              s_axis_tvalid,
    input logic              s_axis_tready,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [151:0]      m_axis_tdata,
    input logic [KIND_W-1:0] m_axis_tuser
);

    // A result that is not taken stays offered unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // Only one frame is in work: the input closes right after a request.
    a_one_frame: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second request taken while a frame is in work");

    // The frame kind is one of the five defined kinds.
    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tuser <= KIND_SPEED)
        else $error("frame kind out of range");

    // State of charge never exceeds full scale.
    a_soc_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[14:1] <= SOC_W'(SOC_FULL_SCALE))
        else $error("state of charge above full scale");

endmodule

bind bms_can_frame_decoder bcfd_checker u_bcfd_checker (.*);

// ===== tb/tb.sv =====
// Self-checking testbench for bms_can_frame_decoder: streams CAN frames in and checks
// every snapshot against a fixed-point decoder kept here. Depends on bcfd_pkg and the design.
module tb;
    import bcfd_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              fault;
        logic [SOC_W-1:0]  soc;
        logic [15:0]       temp_low;
        logic [15:0]       temp_high;
        logic [15:0]       cell_high;
        logic [15:0]       cell_low;
        logic [15:0]       current;
        logic [PACK_W-1:0] pack;
        logic [31:0]       speed;
    } snapshot_t;

    typedef enum {RX_ALWAYS, RX_RANDOM, RX_LONG_STALLS, RX_EVERY_THIRD} rx_pattern_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [SERIES_W-1:0] cfg_data = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    // From bit 0: frame_id, frame_length, byte_0 .. byte_7.
    logic [79:0]         s_axis_tdata = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    // From bit 0: fault_active, charge_state, temp_low, temp_high, cell_high, cell_low,
    // current_mag, pack_volts, speed_bits, zero fill.
    logic [151:0]        m_axis_tdata;
    // frame_kind.
    logic [KIND_W-1:0]   m_axis_tuser;

    // Values the decoder is expected to hold, and its series-cell setting.
    logic                held_fault = 1'b0;
    logic [SOC_W-1:0]    held_soc = '0;
    logic [15:0]         held_temp_low = '0;
    logic [15:0]         held_temp_high = '0;
    logic [15:0]         held_cell_high = '0;
    logic [15:0]         held_cell_low = '0;
    logic [15:0]         held_current = '0;
    logic [PACK_W-1:0]   held_pack = '0;
    logic [31:0]         held_speed = '0;
    logic [SERIES_W-1:0] series_setting = SERIES_RESET;

    snapshot_t   expected_snapshots[$];
    int          error_count = 0;
    int          cycle_count = 0;
    int          burst_left = 0;
    int          tx_gap_max = 0;
    int          stall_left = 0;
    rx_pattern_t rx_pattern = RX_ALWAYS;

    bms_can_frame_decoder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #10 clk = ~clk;

    // State of charge in 0.01 % from the doubled mean cell voltage, by linear
    // interpolation between table points. A mean on a shared point takes the lower segment.
    function automatic logic [SOC_W-1:0] charge_from_doubled_mean(input logic [DSUM_W-1:0] dsum);
        longint lo;
        longint hi;
        longint span;
        longint num;
        if (longint'(dsum) <= 2 * longint'(OCV_TABLE[0]))
            return '0;
        if (longint'(dsum) >= 2 * longint'(OCV_TABLE[SOC_TABLE_POINTS-1]))
            return SOC_W'(SOC_FULL_SCALE);
        for (int i = 0; i < SOC_TABLE_POINTS - 1; i++)
        begin
            lo = 2 * longint'(OCV_TABLE[i]);
            hi = 2 * longint'(OCV_TABLE[i+1]);
            if (lo <= longint'(dsum) && longint'(dsum) <= hi)
            begin
                span = hi - lo;
                if (span == 0)
                    return SOC_W'((longint'(i) * SOC_FULL_SCALE) / (SOC_TABLE_POINTS - 1));
                num = (longint'(i) * span + (longint'(dsum) - lo)) * SOC_FULL_SCALE;
                return SOC_W'(num / (span * (SOC_TABLE_POINTS - 1)));
            end
        end
        return '0;
    endfunction

    // Applies one accepted frame to the held values and returns the snapshot it reports.
    function automatic snapshot_t decode_frame(input logic [79:0] frame);
        logic [10:0]       id;
        logic [3:0]        len;
        logic [7:0]        b [8];
        logic [15:0]       raw;
        logic [DSUM_W-1:0] dsum;
        longint            pack;
        snapshot_t         snap;
        id = frame[10:0];
        len = frame[15:12];
        for (int k = 0; k < 8; k++)
            b[k] = frame[16 + 8*k +: 8];
        snap.kind = KIND_IGNORED;
        if (id == ID_FAULT && len >= 1)
        begin
            held_fault = (b[0] == 8'd1);
            snap.kind = KIND_FAULT;
        end
        else if (id == ID_TEMPS && len >= 4)
        begin
            held_temp_low = {b[0], b[1]};
            held_temp_high = {b[2], b[3]};
            snap.kind = KIND_TEMPS;
        end
        else if (id == ID_CELLS && len >= 6)
        begin
            held_cell_high = {b[0], b[1]};
            held_cell_low = {b[2], b[3]};
            raw = {b[4], b[5]};
            held_current = (raw >= CURRENT_MIDSCALE) ? raw - CURRENT_MIDSCALE
                                                     : CURRENT_MIDSCALE - raw;
            dsum = {1'b0, held_cell_high} + {1'b0, held_cell_low};
            pack = (longint'(dsum) * longint'(series_setting)) >>> 1;
            held_pack = (pack > longint'(PACK_VOLTS_MAX)) ? PACK_VOLTS_MAX : PACK_W'(pack);
            held_soc = charge_from_doubled_mean(dsum);
            snap.kind = KIND_CELLS;
        end
        else if (id == ID_SPEED && len >= 4)
        begin
            held_speed = {b[3], b[2], b[1], b[0]};
            snap.kind = KIND_SPEED;
        end
        snap.fault = held_fault;
        snap.soc = held_soc;
        snap.temp_low = held_temp_low;
        snap.temp_high = held_temp_high;
        snap.cell_high = held_cell_high;
        snap.cell_low = held_cell_low;
        snap.current = held_current;
        snap.pack = held_pack;
        snap.speed = held_speed;
        return snap;
    endfunction

    // Payload of a cell frame: big-endian high and low cell voltages, then the raw current.
    function automatic logic [63:0] cells_payload(input logic [15:0] high, input logic [15:0] low,
                                                  input logic [15:0] raw);
        return {16'($urandom), raw[7:0], raw[15:8], low[7:0], low[15:8], high[7:0], high[15:8]};
    endfunction

    // Mostly cell voltages around the table, some on a table point or one step beside it, some anywhere.
    function automatic logic [15:0] pick_cell_voltage();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 6)
            return 16'($urandom_range(24500, 41600));
        if (sel < 8)
            return OCV_TABLE[$urandom_range(0, SOC_TABLE_POINTS - 1)]
                   + 16'($urandom_range(0, 2)) - 16'd1;
        return 16'($urandom);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    task automatic compare_field(input string name, input longint got, input longint want);
        if (got != want)
            report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    // Compares one taken snapshot with the oldest one still expected.
    task automatic check_snapshot();
        snapshot_t want;
        if (expected_snapshots.size() == 0)
        begin
            report_mismatch("snapshot arrived with none expected");
            return;
        end
        want = expected_snapshots.pop_front();
        compare_field("frame_kind", m_axis_tuser, want.kind);
        compare_field("fault_active", m_axis_tdata[0], want.fault);
        compare_field("charge_state", m_axis_tdata[14:1], want.soc);
        compare_field("temp_low", m_axis_tdata[30:15], want.temp_low);
        compare_field("temp_high", m_axis_tdata[46:31], want.temp_high);
        compare_field("cell_high", m_axis_tdata[62:47], want.cell_high);
        compare_field("cell_low", m_axis_tdata[78:63], want.cell_low);
        compare_field("current_mag", m_axis_tdata[94:79], want.current);
        compare_field("pack_volts", m_axis_tdata[116:95], want.pack);
        compare_field("speed_bits", m_axis_tdata[148:117], want.speed);
        compare_field("zero fill", m_axis_tdata[151:149], 0);
    endtask

    // Snapshot side: take and check results, and stall on the chosen pattern.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (m_axis_tvalid && m_axis_tready)
            check_snapshot();
        case (rx_pattern)
            RX_ALWAYS: m_axis_tready <= 1'b1;
            RX_RANDOM: m_axis_tready <= ($urandom_range(0, 1) == 1);
            RX_LONG_STALLS:
            begin
                if (stall_left > 0)
                begin
                    stall_left = stall_left - 1;
                    m_axis_tready <= 1'b0;
                end
                else if ($urandom_range(0, 7) == 0)
                begin
                    stall_left = $urandom_range(4, 20);
                    m_axis_tready <= 1'b0;
                end
                else
                    m_axis_tready <= 1'b1;
            end
            default: m_axis_tready <= (cycle_count % 3 == 0);
        endcase
    end

    // Sends one frame request. The sender runs in bursts; between bursts it idles for a
    // random number of cycles unless gaps are switched off.
    task automatic send_frame(input logic [11:0] id, input logic [3:0] len,
                              input logic [63:0] payload);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 8);
            if (tx_gap_max > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, tx_gap_max)) @(posedge clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {payload, len, id};
        do
            @(posedge clk);
        while (!s_axis_tready);
        expected_snapshots.push_back(decode_frame(s_axis_tdata));
        burst_left--;
    endtask

    // Drops the request line and waits until every expected snapshot has come back.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (expected_snapshots.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_series_cells(input logic [SERIES_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        series_setting = value;
    endtask

    // Every frame kind, short and overlong lengths, the high id bit, and the table ends.
    task automatic test_decode_directed();
        rx_pattern = RX_RANDOM;
        tx_gap_max = 3;
        send_frame(12'h000, 4'd8, {$urandom, $urandom});
        send_frame({1'b0, ID_FAULT}, 4'd1, 64'h1);
        send_frame({1'b0, ID_FAULT}, 4'd0, 64'h0);
        send_frame({1'b1, ID_FAULT}, 4'd8, 64'hFFFF_FFFF_FFFF_FF00);
        send_frame({1'b0, ID_FAULT}, 4'd15, 64'h1);
        send_frame({1'b0, ID_FAULT}, 4'd1, 64'h81);
        send_frame({1'b0, ID_TEMPS}, 4'd4, 64'hFFFF_FFFF_FFFF_FFFF);
        send_frame({1'b0, ID_TEMPS}, 4'd3, 64'h0);
        send_frame({1'b0, ID_TEMPS}, 4'd8, 64'h0000_0000_7856_3412);
        send_frame({1'b0, ID_CELLS}, 4'd5, cells_payload(16'd30000, 16'd30000, 16'h0));
        send_frame({1'b0, ID_CELLS}, 4'd6, cells_payload(16'd25000, 16'd25000, 16'h8000));
        send_frame({1'b0, ID_CELLS}, 4'd6, cells_payload(16'd25000, 16'd25001, 16'h0000));
        send_frame({1'b0, ID_CELLS}, 4'd6, cells_payload(16'd41110, 16'd41110, 16'hFFFF));
        send_frame({1'b0, ID_CELLS}, 4'd7, cells_payload(16'd28710, 16'd28710, 16'h7FFF));
        send_frame({1'b0, ID_CELLS}, 4'd8, cells_payload(16'd35000, 16'd35100, 16'h8001));
        send_frame({1'b0, ID_CELLS}, 4'd8, cells_payload(16'hFFFF, 16'hFFFF, 16'h1234));
        send_frame({1'b0, ID_CELLS}, 4'd15, cells_payload(16'd0, 16'd0, 16'hABCD));
        send_frame({1'b0, ID_CELLS}, 4'd6, cells_payload(16'd41110, 16'd41109, 16'h8000));
        send_frame({1'b1, ID_CELLS}, 4'd6, cells_payload(16'd36290, 16'd36800, 16'h5555));
        send_frame({1'b0, ID_SPEED}, 4'd4, 64'hFFFF_FFFF_FFFF_FFFF);
        send_frame({1'b0, ID_SPEED}, 4'd3, 64'h0);
        send_frame({1'b0, ID_SPEED}, 4'd8, 64'h0000_0000_42C8_1234);
        send_frame(12'h7FF, 4'd8, {$urandom, $urandom});
        send_frame(12'hFFF, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF);
    endtask

    // Series count of zero, one, the nominal full range, the saturating maximum and the
    // reset value, each with cell frames at the largest cell code, at the table top and at random.
    task automatic test_series_extremes();
        logic [SERIES_W-1:0] settings [5];
        settings = '{7'd0, 7'd1, 7'd64, 7'd127, SERIES_RESET};
        rx_pattern = RX_LONG_STALLS;
        tx_gap_max = 5;
        foreach (settings[n])
        begin
            wait_idle();
            write_series_cells(settings[n]);
            send_frame({1'b0, ID_CELLS}, 4'd6, cells_payload(16'hFFFF, 16'hFFFF, 16'h0));
            send_frame({1'b0, ID_CELLS}, 4'd8, cells_payload(16'd41110, 16'd41110, 16'h8000));
            send_frame({1'b0, ID_CELLS}, 4'd6, cells_payload(pick_cell_voltage(),
                                                            pick_cell_voltage(), 16'($urandom)));
        end
    endtask

    // Mostly well-formed frames with random content, plus short frames and noise, in
    // four phases with different settings and handshake patterns.
    task automatic test_random_traffic(input int count);
        int          sel;
        int          min_len;
        logic [10:0] id;
        logic [11:0] full_id;
        logic [3:0]  len;
        logic [63:0] payload;
        for (int phase = 0; phase < 4; phase++)
        begin
            wait_idle();
            write_series_cells((phase == 3) ? SERIES_W'($urandom_range(0, 127))
                               : (phase == 1) ? 7'd1 : (phase == 2) ? 7'd127 : SERIES_RESET);
            rx_pattern = rx_pattern_t'(phase);
            tx_gap_max = (phase == 0) ? 0 : 3 * phase;
            for (int n = 0; n < count / 4; n++)
            begin
                payload = {$urandom, $urandom};
                sel = $urandom_range(0, 99);
                if (sel < 15)
                begin
                    id = ID_FAULT;
                    min_len = 1;
                    case ($urandom_range(0, 2))
                        0: payload[7:0] = 8'd1;
                        1: payload[7:0] = 8'd0;
                        default: ;
                    endcase
                end
                else if (sel < 35)
                begin
                    id = ID_TEMPS;
                    min_len = 4;
                end
                else if (sel < 65)
                begin
                    id = ID_CELLS;
                    min_len = 6;
                    payload = cells_payload(pick_cell_voltage(), pick_cell_voltage(),
                                            ($urandom_range(0, 9) == 0) ? CURRENT_MIDSCALE
                                                                        : 16'($urandom));
                end
                else if (sel < 80)
                begin
                    id = ID_SPEED;
                    min_len = 4;
                end
                else
                begin
                    id = 11'($urandom);
                    min_len = 0;
                end
                full_id = {$urandom_range(0, 1) == 1, id};
                if (min_len == 0 || $urandom_range(0, 9) != 0)
                    len = 4'($urandom_range(min_len, 15));
                else
                    len = 4'($urandom_range(0, min_len - 1));
                send_frame(full_id, len, payload);
            end
        end
    endtask

    // Watchdog: a hung handshake or a lost snapshot ends the run here.
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_decode_directed();
        test_series_extremes();
        test_random_traffic(1600);
        wait_idle();
        repeat (60) @(posedge clk);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
design/bcfd_pkg.sv
design/bcfd_serial_div.sv
design/bcfd_soc_interp.sv
design/bms_can_frame_decoder.sv
design/bcfd_checker.sv
tb/tb.sv
